// ----- hdl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Reference-counted page allocator package
// Shared widths, sizes and operation and status codes of the allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int PAGE_W    = 15;
    localparam int COUNT_W   = 8;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int NUM_PAGES = 32768;
    localparam int DEPTH_W   = 16;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [PAGE_W-1:0]  PAGE_MAX  = PAGE_W'(NUM_PAGES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 3'd0,
        FUNC_FREE   = 3'd1,
        FUNC_INCREF = 3'd2,
        FUNC_DECREF = 3'd3,
        FUNC_GETREF = 3'd4,
        FUNC_INIT   = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_UNDER = 2'd2,
        STAT_OVER  = 2'd3
    } status_t;

    typedef enum logic {
        REG_FIRST = 1'b0,
        REG_LAST  = 1'b1
    } reg_sel_t;

endpackage

// ----- hdl/rpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/refcounted_page_allocator.sv -----
// ----------------------------------------------------------------------------
// Reference-counted page allocator
// Free-stack page allocator with a saturating reference count per page.
// ----------------------------------------------------------------------------
// In the cycle a transfer is accepted, the count memory and the free stack
// are read; in the execute state, once the output register is free, the
// updated count and any push are written back and the result is loaded into
// the output register. Init sweeps all 32768 pages, one per cycle, clearing
// the counts and refilling the stack with pages first_reg to last_reg.
// After reset the count memory is cleared by the same sweep before the first
// input transfer is accepted; configuration writes are taken meanwhile.
module refcounted_page_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // func [2:0], page_index [17:3], zero [23:18]
    input  logic [rpa_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // result_page [14:0], ref_count [22:15], status [24:23], zero [31:25]
    output logic [rpa_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpa_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpa_pkg::DATA_W-1:0]   pwdata,
    output logic [rpa_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } state_t;

    state_t                         state_reg, state_next;
    logic [rpa_pkg::PAGE_W-1:0]     sweep_reg, sweep_next;
    logic                           init_mode_reg, init_mode_next;
    logic [rpa_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic [rpa_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [rpa_pkg::PAGE_W-1:0]     page_reg, page_next;
    logic [rpa_pkg::PAGE_W-1:0]     first_reg, last_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rpa_pkg::PAGE_W-1:0]     res_page_reg, res_page_next;
    logic [rpa_pkg::COUNT_W-1:0]    res_count_reg, res_count_next;
    logic [rpa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;

    logic                           accept;
    logic                           out_free;
    logic                           cfg_write;
    logic [rpa_pkg::FUNC_W-1:0]     in_func;
    logic [rpa_pkg::PAGE_W-1:0]     in_page;

    logic                           cnt_we;
    logic [rpa_pkg::PAGE_W-1:0]     cnt_waddr;
    logic [rpa_pkg::COUNT_W-1:0]    cnt_wdata;
    logic [rpa_pkg::COUNT_W-1:0]    cnt_rdata;
    logic                           stk_we;
    logic [rpa_pkg::PAGE_W-1:0]     stk_waddr;
    logic [rpa_pkg::PAGE_W-1:0]     stk_wdata;
    logic [rpa_pkg::PAGE_W-1:0]     stk_raddr;
    logic [rpa_pkg::PAGE_W-1:0]     stk_rdata;

    assign in_func   = s_tdata[rpa_pkg::FUNC_W-1:0];
    assign in_page   = s_tdata[rpa_pkg::FUNC_W +: rpa_pkg::PAGE_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign stk_raddr = rpa_pkg::PAGE_W'(depth_reg - 1'b1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(rpa_pkg::OUT_W - rpa_pkg::PAGE_W - rpa_pkg::COUNT_W
                        - rpa_pkg::STATUS_W)'(0),
                       res_status_reg, res_count_reg, res_page_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == rpa_pkg::REG_LAST)
                     ? rpa_pkg::DATA_W'(last_reg) : rpa_pkg::DATA_W'(first_reg);

    rpa_ram #(
        .WIDTH (rpa_pkg::COUNT_W),
        .DEPTH (rpa_pkg::NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (in_page),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (rpa_pkg::PAGE_W),
        .DEPTH (rpa_pkg::NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        init_mode_next  = init_mode_reg;
        depth_next      = depth_reg;
        func_next       = func_reg;
        page_next       = page_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        res_page_next   = res_page_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = page_reg;
        cnt_wdata       = '0;
        stk_we          = 1'b0;
        stk_waddr       = depth_reg[rpa_pkg::PAGE_W-1:0];
        stk_wdata       = page_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_func;
                    page_next = in_page;
                    if (in_func == rpa_pkg::FUNC_INIT)
                    begin
                        state_next     = S_CLEAR;
                        sweep_next     = '0;
                        init_mode_next = 1'b1;
                        depth_next     = '0;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = '0;
                if (init_mode_reg && (sweep_reg >= first_reg) && (sweep_reg <= last_reg))
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = sweep_reg - first_reg;
                    stk_wdata  = sweep_reg;
                    depth_next = depth_reg + 1'b1;
                end
                if (sweep_reg == rpa_pkg::PAGE_MAX)
                begin
                    state_next     = init_mode_reg ? S_EXEC : S_IDLE;
                    init_mode_next = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    m_tvalid_next   = 1'b1;
                    res_page_next   = page_reg;
                    res_count_next  = cnt_rdata;
                    res_status_next = rpa_pkg::STAT_OK;
                    unique case (func_reg)
                        rpa_pkg::FUNC_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_page_next   = '0;
                                res_count_next  = '0;
                                res_status_next = rpa_pkg::STAT_OOM;
                            end
                            else
                            begin
                                depth_next     = depth_reg - 1'b1;
                                res_page_next  = stk_rdata;
                                res_count_next = rpa_pkg::COUNT_W'(1);
                                cnt_we         = 1'b1;
                                cnt_waddr      = stk_rdata;
                                cnt_wdata      = rpa_pkg::COUNT_W'(1);
                            end
                        end
                        rpa_pkg::FUNC_FREE, rpa_pkg::FUNC_DECREF:
                        begin
                            if (cnt_rdata == '0)
                            begin
                                res_status_next = rpa_pkg::STAT_UNDER;
                            end
                            else
                            begin
                                cnt_we         = 1'b1;
                                cnt_wdata      = cnt_rdata - 1'b1;
                                res_count_next = cnt_rdata - 1'b1;
                                if ((func_reg == rpa_pkg::FUNC_FREE)
                                    && (cnt_rdata == rpa_pkg::COUNT_W'(1))
                                    && (depth_reg < rpa_pkg::DEPTH_W'(rpa_pkg::NUM_PAGES)))
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                end
                            end
                        end
                        rpa_pkg::FUNC_INCREF:
                        begin
                            if (cnt_rdata == rpa_pkg::COUNT_MAX)
                            begin
                                res_status_next = rpa_pkg::STAT_OVER;
                            end
                            else
                            begin
                                cnt_we         = 1'b1;
                                cnt_wdata      = cnt_rdata + 1'b1;
                                res_count_next = cnt_rdata + 1'b1;
                            end
                        end
                        rpa_pkg::FUNC_INIT:
                        begin
                            res_count_next = '0;
                        end
                        default:
                        begin
                            res_count_next = cnt_rdata;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            init_mode_reg <= 1'b0;
            depth_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            first_reg     <= '0;
            last_reg      <= rpa_pkg::PAGE_MAX;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_mode_reg <= init_mode_next;
            depth_reg     <= depth_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_write)
            begin
                if (paddr[2] == rpa_pkg::REG_LAST)
                begin
                    last_reg <= pwdata[rpa_pkg::PAGE_W-1:0];
                end
                else
                begin
                    first_reg <= pwdata[rpa_pkg::PAGE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        page_reg       <= page_next;
        res_page_reg   <= res_page_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= rpa_pkg::DEPTH_W'(rpa_pkg::NUM_PAGES))
        else $error("free stack depth exceeds the page count");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input accepted during the clearing sweep");

    a_oom_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && out_free && func_reg == rpa_pkg::FUNC_ALLOC
         && depth_reg == '0) |=> (m_tvalid && res_status_reg == rpa_pkg::STAT_OOM))
        else $error("alloc on an empty stack did not report out of memory");

    a_push_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && stk_we) |-> (cnt_we && cnt_wdata == '0))
        else $error("page pushed while its count is not zero");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped before transfer");

endmodule
